[rtl/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/asu_pkg.sv]
`default_nettype none
package asu_pkg;

  localparam int unsigned BlinkCountBitsDef = 17;

  localparam int unsigned UnitAddrW  = 7;
  localparam int unsigned IntervalW  = 17;
  localparam int unsigned HoldW      = 16;
  localparam int unsigned CfgDataW   = 17;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [7:0] BroadcastAddr = 8'h80;
  localparam logic [7:0] ModeStatus    = 8'h00;
  localparam logic [7:0] ModeSet       = 8'h01;

  localparam logic [6:0]  UnitAddrRst  = 7'd1;
  localparam logic [16:0] IntervalRst  = 17'd100000;
  localparam logic [15:0] HoldRst      = 16'd65000;

  // Status register bit positions
  localparam int unsigned BitMark  = 7;
  localparam int unsigned BitLock  = 6;
  localparam int unsigned BitPhase = 5;
  localparam int unsigned BitBtn   = 4;

  localparam logic [2:0] PinLeft   = 3'b100;
  localparam logic [2:0] PinCenter = 3'b010;
  localparam logic [2:0] PinRight  = 3'b001;

  typedef enum logic [1:0] {
    CmdOff   = 2'd0,
    CmdLeft  = 2'd1,
    CmdRight = 2'd2,
    CmdLock  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    LampNone  = 2'd0,
    LampLeft  = 2'd1,
    LampRight = 2'd2,
    LampGo    = 2'd3
  } lamp_e;

  typedef enum logic [1:0] {
    DevArrow  = 2'd0,
    DevButton = 2'd1,
    DevSignal = 2'd2
  } dev_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgUnitAddr = 2'd0,
    CfgDevType  = 2'd1,
    CfgBlink    = 2'd2,
    CfgHold     = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    KindByte = 1'b0,
    KindTick = 1'b1
  } kind_e;

  function automatic logic [2:0] sel_pin(lamp_e sel);
    logic [2:0] pin;
    unique case (sel)
      LampNone:  pin = 3'b000;
      LampLeft:  pin = PinLeft;
      LampRight: pin = PinRight;
      LampGo:    pin = PinCenter;
      default:   pin = 3'b000;
    endcase
    return pin;
  endfunction

endpackage
`default_nettype wire

[rtl/addressed_signal_unit_slave.sv]
// Inputs pass the input register, then the result register, before the first result shows.
// Throughput: one item per cycle unless out_ready_i stalls; a replying byte gives 3 results.
// Tick items and bytes without a reply each give exactly one result.
// Reset (rst_ni low, asynchronous): all state and configuration registers take their
// documented reset values and both pipeline stages empty; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
module addressed_signal_unit_slave import asu_pkg::*; #(
  parameter int unsigned BlinkCountBits = BlinkCountBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                mode_i,
  input  wire logic [7:0]          rx_byte_i,
  input  wire logic                button_level_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     tx_valid_o,
  output logic [7:0]               tx_byte_o,
  output logic                     run_last_o,
  output logic [2:0]               lamp_pins_o,
  output logic [7:0]               status_out_o
);

  // configuration
  logic [UnitAddrW-1:0] cfg_addr_q;
  dev_e                 cfg_dev_q;
  logic [IntervalW-1:0] cfg_blink_q;
  logic [HoldW-1:0]     cfg_hold_q;

  // input register
  logic       s1_vld_q;
  kind_e      s1_kind_q;
  logic [7:0] s1_rx_q;
  logic       s1_btn_q;

  // unit state
  logic [1:0]                byte_cnt_q, byte_cnt_d;
  logic [7:0]                held_addr_q, held_addr_d;
  logic [7:0]                held_cmd_q, held_cmd_d;
  logic [7:0]                status_q, status_d;
  logic [BlinkCountBits-1:0] blink_q, blink_d, blink_nx;
  lamp_e                     lamp_sel_q, lamp_sel_d;
  logic [HoldW-1:0]          hold_q, hold_d;
  logic [2:0]                pin_q, pin_d, lamp_mask;
  logic                      arrow;
  logic                      reply;
  logic [7:0]                reply_data;

  // result group register
  logic [1:0] grp_cnt_q;
  logic       grp_reply_q;
  logic [7:0] grp_addr_q, grp_cmd_q, grp_data_q;
  logic [2:0] grp_pins_q;
  logic [7:0] grp_stat_q;

  logic out_take, grp_free, s1_adv;

  assign out_valid_o = (grp_cnt_q != 2'd0);
  assign out_take    = out_valid_o && out_ready_i;
  assign grp_free    = (grp_cnt_q == 2'd0) || ((grp_cnt_q == 2'd1) && out_ready_i);
  assign s1_adv      = s1_vld_q && grp_free;
  assign in_ready_o  = !s1_vld_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_addr_q  <= UnitAddrRst;
      cfg_dev_q   <= DevArrow;
      cfg_blink_q <= IntervalRst;
      cfg_hold_q  <= HoldRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgUnitAddr: cfg_addr_q  <= cfg_data_i[UnitAddrW-1:0];
        CfgDevType:  cfg_dev_q   <= dev_e'(cfg_data_i[1:0]);
        CfgBlink:    cfg_blink_q <= cfg_data_i[IntervalW-1:0];
        CfgHold:     cfg_hold_q  <= cfg_data_i[HoldW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_kind_q <= kind_e'(mode_i);
      s1_rx_q   <= rx_byte_i;
      s1_btn_q  <= button_level_i;
    end
  end

  always_comb begin
    byte_cnt_d  = byte_cnt_q;
    held_addr_d = held_addr_q;
    held_cmd_d  = held_cmd_q;
    status_d    = status_q;
    blink_d     = blink_q;
    blink_nx    = blink_q;
    lamp_sel_d  = lamp_sel_q;
    hold_d      = hold_q;
    pin_d       = pin_q;
    lamp_mask   = 3'b000;
    arrow       = (cfg_dev_q == DevArrow);
    reply       = 1'b0;
    reply_data  = (held_cmd_q == ModeStatus) ? status_q : s1_rx_q;
    reply_data[BitMark] = 1'b1;

    if (s1_kind_q == KindByte) begin
      unique case (byte_cnt_q)
        2'd0: begin
          held_addr_d = s1_rx_q;
          byte_cnt_d  = 2'd1;
        end
        2'd1: begin
          held_cmd_d = s1_rx_q;
          byte_cnt_d = 2'd2;
        end
        default: begin
          byte_cnt_d = 2'd0;
          if (held_addr_q == {1'b0, cfg_addr_q}) begin
            reply    = 1'b1;
            status_d = reply_data;
          end else if (held_addr_q == BroadcastAddr && held_cmd_q == ModeSet &&
                       s1_rx_q[1:0] == CmdOff) begin
            status_d = s1_rx_q;
          end
        end
      endcase
    end else begin
      if (cfg_dev_q == DevButton) begin
        if (!s1_btn_q) begin
          hold_d = (hold_q != '1) ? hold_q + HoldW'(1) : hold_q;
        end else begin
          hold_d = '0;
        end
        if (hold_d == cfg_hold_q) status_d[BitBtn] = 1'b1;
      end else if (cfg_dev_q == DevArrow || cfg_dev_q == DevSignal) begin
        if (cmd_e'(status_q[1:0]) == CmdOff) begin
          pin_d = pin_q & (arrow ? 3'b000 : PinRight);
        end else begin
          if (!status_q[BitLock]) begin
            status_d[BitLock] = 1'b1;
            pin_d = pin_q & ~sel_pin(lamp_sel_q);
            if (arrow) begin
              if (cmd_e'(status_q[1:0]) == CmdLeft) lamp_sel_d = LampLeft;
              else if (cmd_e'(status_q[1:0]) == CmdRight) lamp_sel_d = LampRight;
            end else begin
              if (cmd_e'(status_q[1:0]) == CmdRight) lamp_sel_d = LampGo;
              else if (cmd_e'(status_q[1:0]) == CmdLeft) lamp_sel_d = LampLeft;
            end
          end
          lamp_mask = sel_pin(lamp_sel_d) | (arrow ? PinCenter : 3'b000);
          pin_d = status_q[BitPhase] ? (pin_d | lamp_mask) : (pin_d & ~lamp_mask);
        end
      end

      // blink phase runs for every device type; the button type holds its counter
      if (32'(blink_q) == 32'(cfg_blink_q)) begin
        status_d[BitPhase] = ~status_d[BitPhase];
        blink_nx = '0;
      end
      blink_d = (cfg_dev_q != DevButton) ? blink_nx + BlinkCountBits'(1) : blink_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q  <= 2'd0;
      held_addr_q <= 8'h00;
      held_cmd_q  <= 8'h00;
      status_q    <= 8'h00;
      blink_q     <= '0;
      lamp_sel_q  <= LampNone;
      hold_q      <= '0;
      pin_q       <= 3'b000;
    end else if (s1_adv) begin
      byte_cnt_q  <= byte_cnt_d;
      held_addr_q <= held_addr_d;
      held_cmd_q  <= held_cmd_d;
      status_q    <= status_d;
      blink_q     <= blink_d;
      lamp_sel_q  <= lamp_sel_d;
      hold_q      <= hold_d;
      pin_q       <= pin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_cnt_q <= 2'd0;
    end else if (s1_adv) begin
      grp_cnt_q <= reply ? 2'd3 : 2'd1;
    end else if (out_take) begin
      grp_cnt_q <= grp_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      grp_reply_q <= reply;
      grp_addr_q  <= held_addr_q;
      grp_cmd_q   <= held_cmd_q;
      grp_data_q  <= reply_data;
      grp_pins_q  <= pin_d;
      grp_stat_q  <= status_d;
    end
  end

  always_comb begin
    unique case (grp_cnt_q)
      2'd3:    tx_byte_o = grp_addr_q;
      2'd2:    tx_byte_o = grp_cmd_q;
      default: tx_byte_o = grp_data_q;
    endcase
    if (!grp_reply_q) tx_byte_o = 8'h00;
  end

  assign tx_valid_o   = grp_reply_q;
  assign run_last_o   = (grp_cnt_q == 2'd1);
  assign lamp_pins_o  = grp_pins_q;
  assign status_out_o = grp_stat_q;

  `ASSERT_CLK(a_single_is_last, out_valid_o && !tx_valid_o |-> run_last_o,
              "single result item not marked last")
  `ASSERT_CLK(a_reply_data_mark, out_valid_o && tx_valid_o && run_last_o |-> tx_byte_o[7],
              "reply data byte lacks the mark bit")
  `ASSERT_CLK(a_reply_continues,
              out_valid_o && tx_valid_o && !run_last_o && out_ready_i |=> out_valid_o && tx_valid_o,
              "reply broken off before its last byte")
  `ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o, "result pending during reset")

endmodule
`default_nettype wire

[tb/asu_reply_checker.sv]
`timescale 1ns / 1ps
module asu_reply_checker import asu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                mode_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                button_level_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                tx_valid_i,
  input  logic [7:0]          tx_byte_i,
  input  logic                run_last_i,
  input  logic [2:0]          lamp_pins_i,
  input  logic [7:0]          status_out_i,
  output int                  mismatches_o,
  output int                  pending_o
);

  localparam int MaxReports = 100;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       run_last;
    logic [2:0] lamp_pins;
    logic [7:0] status;
  } unit_result_t;

  unit_result_t due_results[$];

  // configuration copy
  logic [UnitAddrW-1:0] unit_addr;
  logic [1:0]           dev_type;
  logic [IntervalW-1:0] blink_limit;
  logic [HoldW-1:0]     hold_limit;

  // unit state
  logic [1:0]                   byte_idx;
  logic [7:0]                   held_addr;
  logic [7:0]                   held_mode;
  logic [7:0]                   status_q;
  logic [BlinkCountBitsDef-1:0] blink_cnt;
  lamp_e                        lamp_sel;
  logic [HoldW-1:0]             hold_cnt;
  logic [2:0]                   pins;

  unit_result_t got;
  unit_result_t want;

  function automatic logic [2:0] lamp_bit(lamp_e sel);
    case (sel)
      LampLeft:  return PinLeft;
      LampRight: return PinRight;
      LampGo:    return PinCenter;
      default:   return 3'b000;
    endcase
  endfunction

  task automatic note_result(logic valid, logic [7:0] data, logic last);
    due_results.push_back('{valid, data, last, pins, status_q});
  endtask

  task automatic update_lamps(logic arrow);
    logic [1:0] cmd;
    logic [2:0] mask;
    cmd = status_q[1:0];
    if (cmd == CmdOff) begin
      // the signal leaves the right lamp alone
      pins = pins & (arrow ? 3'b000 : PinRight);
    end else begin
      if (!status_q[BitLock]) begin
        status_q[BitLock] = 1'b1;
        pins = pins & ~lamp_bit(lamp_sel);
        if (arrow) begin
          if (cmd == CmdLeft) lamp_sel = LampLeft;
          else if (cmd == CmdRight) lamp_sel = LampRight;
        end else begin
          if (cmd == CmdRight) lamp_sel = LampGo;
          else if (cmd == CmdLeft) lamp_sel = LampLeft;
        end
      end
      mask = lamp_bit(lamp_sel) | (arrow ? PinCenter : 3'b000);
      pins = status_q[BitPhase] ? (pins | mask) : (pins & ~mask);
    end
  endtask

  task automatic advance_tick(logic level);
    case (dev_type)
      DevArrow: update_lamps(1'b1);
      DevButton: begin
        if (!level) begin
          if (hold_cnt != '1) hold_cnt = hold_cnt + 1'b1;
        end else begin
          hold_cnt = '0;
        end
        if (hold_cnt == hold_limit) status_q[BitBtn] = 1'b1;
      end
      DevSignal: update_lamps(1'b0);
      default: ;
    endcase
    if (blink_cnt == blink_limit) begin
      status_q[BitPhase] = ~status_q[BitPhase];
      blink_cnt = '0;
    end
    // the button holds the blink counter still
    if (dev_type != DevButton) blink_cnt = blink_cnt + 1'b1;
    note_result(1'b0, 8'h00, 1'b1);
  endtask

  task automatic absorb_byte(logic [7:0] rx);
    logic [7:0] data;
    case (byte_idx)
      2'd0: begin
        held_addr = rx;
        byte_idx = 2'd1;
      end
      2'd1: begin
        held_mode = rx;
        byte_idx = 2'd2;
      end
      default: begin
        data = rx;
        byte_idx = 2'd0;
        if (held_addr == {1'b0, unit_addr}) begin
          if (held_mode == ModeStatus) data = status_q;
          data[BitMark] = 1'b1;
          status_q = data;
          note_result(1'b1, held_addr, 1'b0);
          note_result(1'b1, held_mode, 1'b0);
          note_result(1'b1, data, 1'b1);
          return;
        end
        if (held_addr == BroadcastAddr && held_mode == ModeSet && data[1:0] == CmdOff)
          status_q = data;
      end
    endcase
    note_result(1'b0, 8'h00, 1'b1);
  endtask

  task automatic check_field(string field, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      mismatches_o++;
      if (mismatches_o <= MaxReports)
        $error("%s: expected 0x%0h, got 0x%0h", field, exp_val, act_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_addr   = UnitAddrRst;
      dev_type    = DevArrow;
      blink_limit = IntervalRst;
      hold_limit  = HoldRst;
      byte_idx    = 2'd0;
      held_addr   = 8'h00;
      held_mode   = 8'h00;
      status_q    = 8'h00;
      blink_cnt   = '0;
      lamp_sel    = LampNone;
      hold_cnt    = '0;
      pins        = 3'b000;
      due_results.delete();
    end else begin
      // compare first: a result never stems from the item taken at this edge
      if (out_valid_i && out_ready_i) begin
        got = '{tx_valid_i, tx_byte_i, run_last_i, lamp_pins_i, status_out_i};
        if (due_results.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= MaxReports)
            $error("result with nothing expected: tx_byte 0x%0h", tx_byte_i);
        end else begin
          want = due_results.pop_front();
          check_field("tx_valid", want.tx_valid, got.tx_valid);
          check_field("tx_byte", want.tx_byte, got.tx_byte);
          check_field("run_last", want.run_last, got.run_last);
          check_field("lamp_pins", want.lamp_pins, got.lamp_pins);
          check_field("status_out", want.status, got.status);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgUnitAddr: unit_addr = cfg_data_i[UnitAddrW-1:0];
          CfgDevType:  dev_type = cfg_data_i[1:0];
          CfgBlink:    blink_limit = cfg_data_i[IntervalW-1:0];
          CfgHold:     hold_limit = cfg_data_i[HoldW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (mode_i == KindTick) advance_tick(button_level_i);
        else absorb_byte(rx_byte_i);
      end
    end
    pending_o = due_results.size();
  end

endmodule

[tb/addressed_signal_unit_slave_test.sv]
`timescale 1ns / 1ps
module addressed_signal_unit_slave_test;
  import asu_pkg::*;

  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseItems   = 14;
  localparam logic [1:0]  DevNoLogic   = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic                mode;
  logic [7:0]          rx_byte;
  logic                button_level;
  logic                out_valid;
  logic                out_ready;
  logic                tx_valid;
  logic [7:0]          tx_byte;
  logic                run_last;
  logic [2:0]          lamp_pins;
  logic [7:0]          status_out;

  int mismatches;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  int cycle_count;
  int item_count;
  int byte_phase;
  logic [6:0] cur_addr;

  addressed_signal_unit_slave u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode),
    .rx_byte_i      (rx_byte),
    .button_level_i (button_level),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .tx_valid_o     (tx_valid),
    .tx_byte_o      (tx_byte),
    .run_last_o     (run_last),
    .lamp_pins_o    (lamp_pins),
    .status_out_o   (status_out)
  );

  asu_reply_checker u_reply_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .mode_i         (mode),
    .rx_byte_i      (rx_byte),
    .button_level_i (button_level),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .tx_valid_i     (tx_valid),
    .tx_byte_i      (tx_byte),
    .run_last_i     (run_last),
    .lamp_pins_i    (lamp_pins),
    .status_out_i   (status_out),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic offer_item(kind_e kind, logic [7:0] rx, logic level);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= kind;
    rx_byte      <= rx;
    button_level <= level;
    do @(posedge clk); while (!in_ready);
    item_count++;
    if (kind == KindByte) byte_phase = (byte_phase + 1) % 3;
  endtask

  task automatic send_packet(logic [7:0] addr, logic [7:0] pkt_mode, logic [7:0] data);
    offer_item(KindByte, addr, 1'($urandom));
    offer_item(KindByte, pkt_mode, 1'($urandom));
    offer_item(KindByte, data, 1'($urandom));
  endtask

  // level 0 means pressed
  task automatic send_ticks(int count, int press_pct);
    for (int i = 0; i < count; i++)
      offer_item(KindTick, 8'($urandom), ($urandom_range(99) < press_pct) ? 1'b0 : 1'b1);
  endtask

  // let the checker count the item taken at this edge before looking at pending
  task automatic wait_replies_done();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic load_config(logic [6:0] addr, logic [1:0] dev, logic [16:0] interval,
                             logic [15:0] hold);
    cur_addr = addr;
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgUnitAddr;
    cfg_data <= CfgDataW'(addr);
    @(posedge clk);
    cfg_idx  <= CfgDevType;
    cfg_data <= CfgDataW'(dev);
    @(posedge clk);
    cfg_idx  <= CfgBlink;
    cfg_data <= CfgDataW'(interval);
    @(posedge clk);
    cfg_idx  <= CfgHold;
    cfg_data <= CfgDataW'(hold);
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic random_traffic();
    int pick;
    int sel;
    logic [7:0] addr;
    logic [7:0] pkt_mode;
    pick = $urandom_range(99);
    if (pick < 45) begin
      // finish any torn packet so this one lines up
      while (byte_phase != 0) offer_item(KindByte, 8'($urandom), 1'($urandom));
      sel = $urandom_range(99);
      if (sel < 55) addr = {1'b0, cur_addr};
      else if (sel < 75) addr = BroadcastAddr;
      else if (sel < 85) addr = {1'b1, 7'($urandom)};
      else addr = 8'($urandom);
      sel = $urandom_range(99);
      if (sel < 40) pkt_mode = ModeStatus;
      else if (sel < 80) pkt_mode = ModeSet;
      else pkt_mode = 8'($urandom);
      send_packet(addr, pkt_mode, 8'($urandom));
    end else if (pick < 85) begin
      send_ticks($urandom_range(1, 8), 80);
    end else begin
      // stray bytes tear the packet framing
      for (int i = 0; i < $urandom_range(1, 2); i++)
        offer_item(KindByte, 8'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int start;
    bit paused;
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CfgUnitAddr;
    cfg_data       = '0;
    in_valid       = 1'b0;
    mode           = KindByte;
    rx_byte        = 8'h00;
    button_level   = 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cycle_count    = 0;
    item_count     = 0;
    byte_phase     = 0;
    cur_addr       = UnitAddrRst;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset configuration, arrow unit at address one
    send_ticks(1, 100);
    send_ticks(1, 0);
    send_packet({1'b0, cur_addr}, ModeStatus, 8'h00);
    // lock command with no lamp chosen: only the center lamp follows the phase
    send_packet({1'b0, cur_addr}, ModeSet, 8'h03);
    send_ticks(1, 50);
    // broadcast set with command off is taken, phase bit set
    send_packet(BroadcastAddr, ModeSet, 8'h20);
    send_ticks(1, 50);
    send_packet({1'b0, cur_addr}, ModeSet, 8'h21);
    send_ticks(1, 50);
    // broadcast in status mode is dropped
    send_packet(BroadcastAddr, ModeStatus, 8'h00);
    send_packet(8'hFF, 8'hFF, 8'hFF);

    for (int ph = 0; ph < 8; ph++) begin
      wait_replies_done();
      case (ph)
        0: load_config(7'd5, DevArrow, 17'd2, 16'd3);
        1: load_config(7'd0, DevSignal, 17'd1, 16'd1);
        2: load_config(7'd127, DevButton, 17'd3, 16'd2);
        3: load_config(7'd42, DevNoLogic, 17'd4, 16'd5);
        4: load_config(7'($urandom), DevArrow, 17'd1, 16'd1);
        5: load_config(7'($urandom), DevSignal, 17'd3, 16'd4);
        6: load_config(7'($urandom), DevButton, 17'd1, 16'hFFFF);
        default: load_config(7'd127, DevArrow, 17'h1FFFF, 16'd3);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      start  = item_count;
      paused = 1'b0;
      while (item_count - start < PhaseItems) begin
        if (!paused && item_count - start >= PhaseItems / 2) begin
          wait_replies_done();
          paused = 1'b1;
        end
        random_traffic();
      end
    end

    wait_replies_done();
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
